/* rtl/core/css_pkg.sv */
// Package for the CPU schedule simulator: payload structs, policy codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package css_pkg;
    localparam int MAX_PROCS_DEF = 32;
    localparam int TW = 22;

    typedef enum logic [1:0] {
        POL_FCFS = 2'd0,
        POL_SJF  = 2'd1,
        POL_PRIO = 2'd2,
        POL_RR   = 2'd3
    } t_policy;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_QUANTUM = 2'd1;

    typedef struct packed {
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [7:0]  priority_level;
        logic        last_record;
    } t_in_item;

    typedef struct packed {
        logic [4:0]    process_index;
        logic [TW-1:0] completion_time;
        logic [TW-1:0] turnaround_time;
        logic [TW-1:0] waiting_time;
        logic          overflow_flag;
        logic          last_result;
    } t_out_item;
endpackage

/* rtl/core/css_ram.sv */
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module css_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/core/cpu_schedule_simulator.sv */
// Top level of the CPU schedule simulator: APB registers, record store and scheduling
// sequencer. Depends on css_pkg and css_ram.
`timescale 1ns / 1ps
// Records load one per cycle while input ready is high. On the record marked last the
// block runs the schedule. Setup does one read and one write per stored process. Each
// decision is one scan over the stored processes through a shared comparator: a read
// and a compare state per process, then a decision state. There is one decision per
// process plus idle jumps (FCFS/SJF/priority), or one per quantum slice plus idle
// jumps (round robin). Then one result per process is presented in load order via a
// read, a wait and a compute state; compute waits for the output register. Input ready
// is low from the last record until the final result is loaded into the output register.
module cpu_schedule_simulator #(
    parameter int MAX_PROCS = css_pkg::MAX_PROCS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  css_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output css_pkg::t_out_item  o_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int TW = css_pkg::TW;
    localparam int KW = TW + 1;
    localparam int EW = 16 + 16 + 8;

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_SRD, S_SCMP, S_DEC, S_ORD, S_OWAIT, S_OCALC, S_OOUT
    } t_state;

    t_state r_state;
    logic [1:0]  r_mode;
    logic [15:0] r_quantum;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [TW-1:0] r_now;
    logic [MAX_PROCS-1:0] r_done;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_left;
    logic [AW-1:0] r_best;
    logic          r_found, r_any;
    logic [KW-1:0] r_next;
    logic [EW-1:0] r_bent;
    logic [KW-1:0] r_bkey;
    logic [15:0]   r_brem;
    logic          r_ovalid;
    css_pkg::t_out_item r_odata;

    // static record store, dynamic state store and completion time store
    logic          st_we, dy_we;
    logic [AW-1:0] st_wa, dy_wa, rd_a;
    logic [EW-1:0] st_wd, st_rd;
    logic [KW+16-1:0] dy_wd, dy_rd;
    logic [TW-1:0] cm_wd, cm_rd;
    logic          cm_we;

    css_ram #(.WIDTH(EW), .DEPTH(MAX_PROCS)) u_rec (
        .i_clk, .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd), .i_raddr(rd_a),
        .o_rdata(st_rd));
    css_ram #(.WIDTH(KW + 16), .DEPTH(MAX_PROCS)) u_dyn (
        .i_clk, .i_we(dy_we), .i_waddr(dy_wa), .i_wdata(dy_wd), .i_raddr(rd_a),
        .o_rdata(dy_rd));
    css_ram #(.WIDTH(TW), .DEPTH(MAX_PROCS)) u_cmp (
        .i_clk, .i_we(cm_we), .i_waddr(r_best), .i_wdata(cm_wd), .i_raddr(rd_a),
        .o_rdata(cm_rd));

    wire [15:0] e_arr = st_rd[EW-1 -: 16];
    wire [15:0] e_bst = st_rd[23:8];
    wire [7:0]  e_pri = st_rd[7:0];
    wire [KW-1:0] e_key = dy_rd[KW+15:16];
    wire [15:0]   e_rem = dy_rd[15:0];
    wire [15:0] b_arr = r_bent[EW-1 -: 16];
    wire [15:0] b_bst = r_bent[23:8];
    wire [7:0]  b_pri = r_bent[7:0];
    wire rr = (r_mode == css_pkg::POL_RR);
    wire [15:0] q = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
    wire [AW-1:0] last_idx = AW'(r_count - CW'(1));
    wire [1:0] reg_idx = {1'b0, paddr[2]};

    // shared compare unit
    logic [KW-1:0] e_when;
    logic          e_rdy, e_beats;
    always_comb begin
        e_when = rr ? KW'((e_key + KW'(1)) >> 1) : KW'(e_arr);
        e_rdy  = rr ? ({e_key} <= {r_now, 1'b1}) : (TW'(e_arr) <= r_now);
        unique case (css_pkg::t_policy'(r_mode))
            css_pkg::POL_SJF:  e_beats = (e_bst != b_bst) ? (e_bst < b_bst) : (e_arr < b_arr);
            css_pkg::POL_PRIO: e_beats = (e_pri != b_pri) ? (e_pri < b_pri) : (e_arr < b_arr);
            css_pkg::POL_RR:   e_beats = (e_key != r_bkey) ? (e_key < r_bkey)
                                                           : (e_arr < b_arr);
            default:           e_beats = e_arr < b_arr;
        endcase
    end

    wire [15:0] slice = (r_brem <= q) ? r_brem : q;
    wire [TW-1:0] adv = rr ? TW'(slice) : TW'(b_bst);
    wire [TW-1:0] now_adv = r_now + adv;
    wire [15:0] rem_new = r_brem - slice;
    wire acc_in = i_valid && o_ready;
    wire [TW-1:0] tat = cm_rd - TW'(e_arr);
    wire out_load = (r_state == S_OCALC) && (!r_ovalid || i_ready);

    always_comb begin
        st_we = acc_in && (r_count < CW'(MAX_PROCS));
        st_wa = AW'(r_count);
        st_wd = {i_data.arrival_time, i_data.burst_time, i_data.priority_level};
        dy_we = 1'b0;
        dy_wa = r_idx;
        dy_wd = {KW'({e_arr, 1'b0}), e_bst};
        cm_we = 1'b0;
        cm_wd = now_adv;
        rd_a  = r_idx;
        if (r_state == S_INIT) begin
            dy_we = 1'b1;
            dy_wa = r_idx;
        end
        if (r_state == S_DEC && r_found) begin
            dy_we = rr;
            dy_wa = r_best;
            dy_wd = {KW'({now_adv, 1'b1}), rem_new};
            cm_we = !rr || (rem_new == 16'd0);
        end
    end

    // S_INIT needs record data at r_idx: handled by a pre-read step flagged by r_ipre
    logic r_ipre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_mode <= 2'd0; r_quantum <= 16'd1;
            r_count <= '0; r_ovf <= 1'b0; r_ovalid <= 1'b0; r_done <= '0;
            r_ipre <= 1'b0; r_idx <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (reg_idx == css_pkg::REG_MODE) r_mode <= pwdata[1:0];
                else r_quantum <= pwdata[15:0];
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_LOAD: if (acc_in) begin
                    if (r_count < CW'(MAX_PROCS)) r_count <= r_count + CW'(1);
                    else r_ovf <= 1'b1;
                    if (i_data.last_record) begin
                        r_idx <= '0; r_ipre <= 1'b1; r_state <= S_INIT;
                        r_now <= '0; r_done <= '0;
                    end
                end
                S_INIT: begin
                    // cycle with r_ipre=1 waits for read data of r_idx
                    if (r_ipre) r_ipre <= 1'b0;
                    else if (r_idx == last_idx) begin
                        r_idx <= '0; r_left <= r_count; r_state <= S_SRD;
                        r_found <= 1'b0; r_any <= 1'b0;
                    end else begin
                        r_idx <= r_idx + AW'(1); r_ipre <= 1'b1;
                    end
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    if (!r_done[r_idx]) begin
                        if (!r_any || e_when < r_next) r_next <= e_when;
                        r_any <= 1'b1;
                        if (e_rdy && (!r_found || e_beats)) begin
                            r_best <= r_idx; r_bent <= st_rd; r_bkey <= e_key;
                            r_brem <= e_rem; r_found <= 1'b1;
                        end
                    end
                    if (r_idx == last_idx) r_state <= S_DEC;
                    else begin r_idx <= r_idx + AW'(1); r_state <= S_SRD; end
                end
                S_DEC: begin
                    if (!r_found) r_now <= TW'(r_next);
                    else begin
                        r_now <= now_adv;
                        if (!rr || rem_new == 16'd0) begin
                            r_done[r_best] <= 1'b1;
                            r_left <= r_left - CW'(1);
                        end
                    end
                    r_idx <= '0; r_found <= 1'b0; r_any <= 1'b0;
                    if (r_found && (!rr || rem_new == 16'd0) && r_left == CW'(1))
                        r_state <= S_ORD;
                    else r_state <= S_SRD;
                end
                S_ORD: r_state <= S_OWAIT;
                S_OWAIT: r_state <= S_OCALC;
                S_OCALC: begin
                    if (out_load) begin
                        r_odata.process_index   <= 5'(r_idx);
                        r_odata.completion_time <= cm_rd;
                        r_odata.turnaround_time <= tat;
                        r_odata.waiting_time    <= tat - TW'(e_bst);
                        r_odata.overflow_flag   <= r_ovf;
                        r_odata.last_result     <= (r_idx == last_idx);
                        if (r_idx == last_idx) begin
                            r_state <= S_LOAD; r_count <= '0; r_ovf <= 1'b0;
                            r_done <= '0;
                        end else begin
                            r_idx <= r_idx + AW'(1); r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_ready = (r_state == S_LOAD);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == css_pkg::REG_QUANTUM) ? {16'd0, r_quantum}
                                                       : {30'd0, r_mode};
endmodule
